// ----- rtl/core/bmpd_pkg.sv -----
`timescale 1ns / 1ps
package bmpd_pkg;

    localparam int MaxDimension = 16384;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SIGNATURE = 3'd1,
        ERR_HDR_SIZE  = 3'd2,
        ERR_DEPTH     = 3'd3,
        ERR_DIMENSION = 3'd4
    } err_t;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_HEADER = 6'b000010,
        PH_SKIP   = 6'b000100,
        PH_PIXEL  = 6'b001000,
        PH_PAD    = 6'b010000,
        PH_HALT   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [13:0] pixel_x;
        logic [13:0] pixel_y;
        logic [14:0] image_width;
        logic [14:0] image_height;
        logic        has_alpha;
        logic        last_pixel;
    } result_t;

endpackage

// ----- rtl/core/bmpd_parser.sv -----
`timescale 1ns / 1ps
module bmpd_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              in_sof,
    output logic              res_valid,
    output bmpd_pkg::result_t res
);

    bmpd_pkg::phase_t phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] offset_reg, offset_next;
    logic        small_reg, small_next;
    logic [14:0] width_reg, width_next;
    logic [14:0] height_reg, height_next;
    logic        four_reg, four_next;
    logic [13:0] col_reg, col_next;
    logic [13:0] rows_reg, rows_next;
    logic [1:0]  ch_reg, ch_next;
    logic [23:0] part_reg, part_next;
    logic [1:0]  pad_reg, pad_next;

    logic [31:0] sh;
    logic [15:0] sh_hi;
    logic [31:0] dimv;
    logic [31:0] offset_min;
    bmpd_pkg::phase_t ph;
    logic [31:0] pos;
    logic [23:0] part_cur;
    logic [1:0]  last_ch;
    logic        end_row;
    logic        end_img;
    logic [13:0] ypos;
    logic [1:0]  pad_calc;

    always_comb begin
        ph         = phase_reg;
        pos        = pos_reg;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        offset_next = offset_reg;
        small_next = small_reg;
        width_next = width_reg;
        height_next = height_reg;
        four_next  = four_reg;
        col_next   = col_reg;
        rows_next  = rows_reg;
        ch_next    = ch_reg;
        part_next  = part_reg;
        pad_next   = pad_reg;
        res_valid  = 1'b0;
        res        = '0;
        sh         = {in_byte, shift_reg[31:8]};
        sh_hi      = sh[31:16];
        dimv       = small_reg ? {16'd0, sh_hi} : sh;
        offset_min = 32'd14 + sh;
        last_ch    = four_reg ? 2'd3 : 2'd2;
        part_cur   = part_reg;
        end_row    = 1'b0;
        end_img    = 1'b0;
        ypos       = 14'(height_reg - 15'd1 - {1'b0, rows_reg});
        pad_calc   = 2'(3'd4 - 3'({1'b0, width_reg[1:0]} * {1'b0, last_ch} + 3'(width_reg[1:0])));
        if (in_valid) begin
            if (in_sof) begin
                ph = bmpd_pkg::PH_HEADER;
                pos = '0;
                sh = {in_byte, 24'd0};
                sh_hi = sh[31:16];
                offset_next = '0;
                small_next = 1'b0;
                width_next = '0;
                height_next = '0;
                four_next = 1'b0;
                col_next = '0;
                rows_next = '0;
                ch_next = '0;
                part_next = '0;
                pad_next = '0;
                phase_next = ph;
            end
            case (ph)
                bmpd_pkg::PH_HEADER: begin
                    shift_next = sh;
                    pos_next = pos + 32'd1;
                    res.image_width = width_next;
                    res.image_height = height_next;
                    if (pos == 32'd1) begin
                        if (sh_hi != 16'h4D42) begin
                            res_valid = 1'b1;
                            res = '0;
                            res.kind = bmpd_pkg::KIND_ERROR;
                            res.error_code = bmpd_pkg::ERR_SIGNATURE;
                            phase_next = bmpd_pkg::PH_HALT;
                        end
                    end else if (pos == 32'd13) begin
                        offset_next = sh;
                    end else if (pos == 32'd17) begin
                        small_next = (sh == 32'd12);
                        if (sh != 32'd12 && sh != 32'd40 && sh != 32'd124) begin
                            res_valid = 1'b1;
                            res = '0;
                            res.kind = bmpd_pkg::KIND_ERROR;
                            res.error_code = bmpd_pkg::ERR_HDR_SIZE;
                            phase_next = bmpd_pkg::PH_HALT;
                        end else if (offset_reg < offset_min) begin
                            res_valid = 1'b1;
                            res = '0;
                            res.kind = bmpd_pkg::KIND_ERROR;
                            res.error_code = bmpd_pkg::ERR_DIMENSION;
                            phase_next = bmpd_pkg::PH_HALT;
                        end
                    end else if (pos == (small_reg ? 32'd19 : 32'd21)
                                 || pos == (small_reg ? 32'd21 : 32'd25)) begin
                        if (dimv > 32'(bmpd_pkg::MaxDimension)) begin
                            res_valid = 1'b1;
                            res = '0;
                            res.kind = bmpd_pkg::KIND_ERROR;
                            res.error_code = bmpd_pkg::ERR_DIMENSION;
                            phase_next = bmpd_pkg::PH_HALT;
                        end else if (pos == (small_reg ? 32'd19 : 32'd21)) begin
                            width_next = dimv[14:0];
                        end else begin
                            height_next = dimv[14:0];
                        end
                    end else if (pos == (small_reg ? 32'd25 : 32'd29)) begin
                        res_valid = 1'b1;
                        res = '0;
                        if (sh_hi != 16'd32 && sh_hi != 16'd24) begin
                            res.kind = bmpd_pkg::KIND_ERROR;
                            res.error_code = bmpd_pkg::ERR_DEPTH;
                            phase_next = bmpd_pkg::PH_HALT;
                        end else begin
                            four_next = (sh_hi == 16'd32);
                            res.kind = bmpd_pkg::KIND_HEADER;
                            res.image_width = width_reg;
                            res.image_height = height_reg;
                            res.has_alpha = four_next;
                            phase_next = (width_reg == '0 || height_reg == '0) ?
                                bmpd_pkg::PH_HALT : bmpd_pkg::PH_SKIP;
                            col_next = '0;
                            rows_next = '0;
                            ch_next = '0;
                            part_next = '0;
                        end
                    end
                end
                bmpd_pkg::PH_SKIP, bmpd_pkg::PH_PIXEL: begin
                    if (ph == bmpd_pkg::PH_SKIP && pos_reg != offset_reg) begin
                        pos_next = pos_reg + 32'd1;
                    end else begin
                        phase_next = bmpd_pkg::PH_PIXEL;
                        case (ch_reg)
                            2'd0: part_cur = {part_reg[23:8], in_byte};
                            2'd1: part_cur = {part_reg[23:16], in_byte, part_reg[7:0]};
                            2'd2: part_cur = {in_byte, part_reg[15:0]};
                            default: part_cur = part_reg;
                        endcase
                        if (ch_reg != last_ch) begin
                            ch_next = ch_reg + 2'd1;
                            part_next = part_cur;
                        end else begin
                            end_row = ({1'b0, col_reg} + 15'd1 == width_reg);
                            end_img = end_row && ({1'b0, rows_reg} + 15'd1 == height_reg);
                            res_valid = 1'b1;
                            res.kind = bmpd_pkg::KIND_PIXEL;
                            res.red = part_cur[23:16];
                            res.green = part_cur[15:8];
                            res.blue = part_cur[7:0];
                            res.alpha = four_reg ? in_byte : 8'd0;
                            res.pixel_x = col_reg;
                            res.pixel_y = ypos;
                            res.image_width = width_reg;
                            res.image_height = height_reg;
                            res.has_alpha = four_reg;
                            res.last_pixel = end_img;
                            ch_next = '0;
                            part_next = '0;
                            if (end_img) begin
                                phase_next = bmpd_pkg::PH_HALT;
                            end else if (end_row) begin
                                col_next = '0;
                                rows_next = rows_reg + 14'd1;
                                pad_next = pad_calc;
                                phase_next = (pad_calc != 2'd0) ?
                                    bmpd_pkg::PH_PAD : bmpd_pkg::PH_PIXEL;
                            end else begin
                                col_next = col_reg + 14'd1;
                            end
                        end
                    end
                end
                bmpd_pkg::PH_PAD: begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_reg == 2'd1) begin
                        phase_next = bmpd_pkg::PH_PIXEL;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= bmpd_pkg::PH_IDLE;
            pos_reg <= '0;
            shift_reg <= '0;
            offset_reg <= '0;
            small_reg <= 1'b0;
            width_reg <= '0;
            height_reg <= '0;
            four_reg <= 1'b0;
            col_reg <= '0;
            rows_reg <= '0;
            ch_reg <= '0;
            part_reg <= '0;
            pad_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            shift_reg <= shift_next;
            offset_reg <= offset_next;
            small_reg <= small_next;
            width_reg <= width_next;
            height_reg <= height_next;
            four_reg <= four_next;
            col_reg <= col_next;
            rows_reg <= rows_next;
            ch_reg <= ch_next;
            part_reg <= part_next;
            pad_reg <= pad_next;
        end
    end

endmodule

// ----- rtl/core/bmpd_queue.sv -----
`timescale 1ns / 1ps
module bmpd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    input  bmpd_pkg::result_t wr_data,
    output logic              space_ok,
    output logic              rd_valid,
    output bmpd_pkg::result_t rd_data,
    input  logic              rd_ready
);

    bmpd_pkg::result_t mem_reg [4];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] cnt_reg;
    logic       do_wr, do_rd;

    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign do_rd    = rd_valid && rd_ready;
    assign do_wr    = wr_valid;
    // Ready needs two free slots: one for the registered result in flight, one for the byte taken now.
    assign space_ok = (cnt_reg <= 3'd2);

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_wr) begin
                wptr_reg <= wptr_reg + 2'd1;
            end
            if (do_rd) begin
                rptr_reg <= rptr_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {2'd0, do_wr} - {2'd0, do_rd};
        end
    end

endmodule

// ----- rtl/core/bmp_stream_decoder.sv -----
`timescale 1ns / 1ps
// BMP stream decoder. Each input request carries one byte of a BMP file in
// file order on s_file_byte, with s_start_of_file high on the first byte.
// The decoder parses the header and emits one header result, then one pixel
// result per pixel with its column and row, or one error result, on the m_
// channel. Both channels use valid and ready.
// A byte is taken every cycle while the result queue has room. A result is
// registered in res_reg when the byte that completes it is accepted, is
// then written into the queue, and is offered on m_ from there. Throughput
// is one byte per cycle while the queue has room.
// The four-entry queue between parser and output lets the receiver stall;
// s_ready drops once the queue holds three results and returns as it drains.
// Synchronous active-low reset empties the queue and returns the parser to
// idle, where bytes are ignored until a start of file arrives.
module bmp_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_file_byte,
    input  logic        s_start_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [2:0]  m_error_code,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha,
    output logic [13:0] m_pixel_x,
    output logic [13:0] m_pixel_y,
    output logic [14:0] m_image_width,
    output logic [14:0] m_image_height,
    output logic        m_has_alpha,
    output logic        m_last_pixel
);

    logic              res_valid;
    bmpd_pkg::result_t res;
    bmpd_pkg::result_t q_out;
    logic              space_ok;
    logic              res_vld_reg;
    bmpd_pkg::result_t res_reg;

    assign s_ready = space_ok && aresetn;

    bmpd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid && s_ready),
        .in_byte   (s_file_byte),
        .in_sof    (s_start_of_file),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        res_reg <= res;
        if (!aresetn) begin
            res_vld_reg <= 1'b0;
        end else begin
            res_vld_reg <= res_valid;
        end
    end

    bmpd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (res_vld_reg),
        .wr_data  (res_reg),
        .space_ok (space_ok),
        .rd_valid (m_valid),
        .rd_data  (q_out),
        .rd_ready (m_ready)
    );

    assign m_kind         = q_out.kind;
    assign m_error_code   = q_out.error_code;
    assign m_red          = q_out.red;
    assign m_green        = q_out.green;
    assign m_blue         = q_out.blue;
    assign m_alpha        = q_out.alpha;
    assign m_pixel_x      = q_out.pixel_x;
    assign m_pixel_y      = q_out.pixel_y;
    assign m_image_width  = q_out.image_width;
    assign m_image_height = q_out.image_height;
    assign m_has_alpha    = q_out.has_alpha;
    assign m_last_pixel   = q_out.last_pixel;

endmodule
